// ===== rtl/drr_pkg.sv =====
package drr_pkg;

  // Table sizes and field widths
  localparam int MAX_CLIENTS = 8;
  localparam int PTR_W       = $clog2(MAX_CLIENTS);
  localparam int CNT_W       = $clog2(MAX_CLIENTS + 1);
  localparam int MASK_W      = 8;
  localparam int DEF_W       = 25;
  localparam int WGT_W       = 8;
  localparam int QNT_W       = 16;
  localparam int COST_W      = 16;
  localparam int PROD_W      = WGT_W + QNT_W;
  localparam int CFG_CNT_W   = 4;

  // Item opcodes
  localparam logic [1:0] OP_PICK   = 2'd0;
  localparam logic [1:0] OP_CHARGE = 2'd1;
  localparam logic [1:0] OP_WEIGHT = 2'd2;
  localparam logic [1:0] OP_REMOVE = 2'd3;

  // Configuration register indexes
  localparam logic REG_QUANTUM = 1'b0;
  localparam logic REG_COUNT   = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic load;      // latch the accepted item
    logic scan;      // examine the client at the pointer
    logic refill;    // refill and grant the client at the pointer
    logic exec;      // charge, set weight or remove
    logic out_load;  // move the result into the output register
  } drr_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic cur_ready;  // client at the pointer has work
    logic scan_last;  // this is the last client of the round
  } drr_status_t;

endpackage

// ===== rtl/drr_ctrl.sv =====
module drr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic [1:0]           in_op_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  drr_pkg::drr_status_t status_i,
  output drr_pkg::drr_cmd_t    cmd_o
);
  import drr_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_REFILL = 3'd2;
  localparam logic [2:0] ST_EXEC   = 3'd3;
  localparam logic [2:0] ST_RESP   = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       in_xfer;
  logic       out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          cmd_o.load = 1'b1;
          state_d    = (in_op_i == OP_PICK) ? ST_SCAN : ST_EXEC;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.cur_ready) begin
          state_d = ST_REFILL;
        end else if (status_i.scan_last) begin
          state_d = ST_RESP;
        end
      end
      ST_REFILL: begin
        cmd_o.refill = 1'b1;
        state_d      = ST_RESP;
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== rtl/drr_datapath.sv =====
module drr_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  drr_pkg::drr_cmd_t                   cmd_i,
  output drr_pkg::drr_status_t                status_o,
  // configuration write
  input  logic                                cfg_we_i,
  input  logic                                cfg_index_i,
  input  logic [drr_pkg::QNT_W-1:0]           cfg_data_i,
  // accepted item
  input  logic [1:0]                          in_op_i,
  input  logic [drr_pkg::MASK_W-1:0]          in_mask_i,
  input  logic [drr_pkg::PTR_W-1:0]           in_client_i,
  input  logic [drr_pkg::COST_W-1:0]          in_cost_i,
  input  logic [drr_pkg::WGT_W-1:0]           in_weight_i,
  // result register
  output logic                                out_granted_o,
  output logic [drr_pkg::PTR_W-1:0]           out_client_o,
  output logic [drr_pkg::PTR_W-1:0]           out_pointer_o,
  output logic [drr_pkg::DEF_W-1:0]           out_deficit_o
);
  import drr_pkg::*;

  // Saturate a one-bit-wider sum to the deficit range
  function automatic logic [DEF_W-1:0] sat_def(input logic [DEF_W:0] v);
    logic [DEF_W-1:0] r;
    if (v[DEF_W] != v[DEF_W-1]) begin
      r = v[DEF_W] ? {1'b1, {(DEF_W-1){1'b0}}} : {1'b0, {(DEF_W-1){1'b1}}};
    end else begin
      r = v[DEF_W-1:0];
    end
    return r;
  endfunction

  // Configuration
  logic [QNT_W-1:0]     quantum_q;
  logic [CNT_W-1:0]     count_q;
  logic [CNT_W-1:0]     count_d;

  // Scheduler state
  logic [DEF_W-1:0]     deficit_q [MAX_CLIENTS];
  logic [WGT_W-1:0]     weight_q  [MAX_CLIENTS];
  logic [PTR_W-1:0]     ptr_q;
  logic [PTR_W-1:0]     last_q;
  logic                 pending_q;
  logic [PTR_W-1:0]     cnt_q;
  logic [PROD_W-1:0]    prod_q;

  // Latched item
  logic [1:0]           op_q;
  logic [MASK_W-1:0]    mask_q;
  logic [PTR_W-1:0]     client_q;
  logic [COST_W-1:0]    cost_q;
  logic [WGT_W-1:0]     weight_in_q;

  // Result before the output register
  logic                 res_granted_q;
  logic [PTR_W-1:0]     res_client_q;
  logic [DEF_W-1:0]     res_deficit_q;

  logic [PTR_W-1:0]     ptr_norm;
  logic [PTR_W-1:0]     ptr_wrap;
  logic [CNT_W-1:0]     ptr_inc;
  logic [PTR_W-1:0]     rd_addr;
  logic [DEF_W-1:0]     rd_def;
  logic [DEF_W-1:0]     refill_def;
  logic [DEF_W-1:0]     charge_def;
  logic                 rd_nonpos;

  // Effective round size from the written value
  always_comb begin
    if (cfg_data_i[CFG_CNT_W-1:0] == '0) begin
      count_d = CNT_W'(1);
    end else if (CNT_W'(cfg_data_i[CFG_CNT_W-1:0]) > CNT_W'(MAX_CLIENTS)) begin
      count_d = CNT_W'(MAX_CLIENTS);
    end else begin
      count_d = CNT_W'(cfg_data_i[CFG_CNT_W-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_q <= QNT_W'(1);
      count_q   <= CNT_W'(1);
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_QUANTUM) begin
        quantum_q <= cfg_data_i;
      end else begin
        count_q <= count_d;
      end
    end
  end

  // Pointer arithmetic: fold an out-of-round pointer to 0, then step with wrap
  assign ptr_norm = ({1'b0, ptr_q} >= count_q) ? '0 : ptr_q;
  assign ptr_inc  = {1'b0, ptr_norm} + CNT_W'(1);
  assign ptr_wrap = (ptr_inc >= count_q) ? '0 : ptr_inc[PTR_W-1:0];

  // Single deficit read port: pointer during a pick, last grant otherwise
  assign rd_addr    = cmd_i.exec ? last_q : ptr_q;
  assign rd_def     = deficit_q[rd_addr];
  assign rd_nonpos  = rd_def[DEF_W-1] || (rd_def == '0);
  assign refill_def = rd_nonpos ?
                      sat_def({rd_def[DEF_W-1], rd_def} + (DEF_W+1)'(prod_q)) : rd_def;
  assign charge_def = sat_def({rd_def[DEF_W-1], rd_def} - (DEF_W+1)'(cost_q));

  assign status_o.cur_ready = mask_q[ptr_q];
  assign status_o.scan_last = ({1'b0, cnt_q} == (count_q - CNT_W'(1)));

  // Item latch and refill product
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q        <= in_op_i;
      mask_q      <= in_mask_i;
      client_q    <= in_client_i;
      cost_q      <= in_cost_i;
      weight_in_q <= in_weight_i;
    end
    if (cmd_i.scan) begin
      prod_q <= weight_q[ptr_q] * quantum_q;
    end
  end

  // Scheduler state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_CLIENTS; i++) begin
        deficit_q[i] <= '0;
        weight_q[i]  <= WGT_W'(1);
      end
      ptr_q         <= '0;
      last_q        <= '0;
      pending_q     <= 1'b0;
      cnt_q         <= '0;
      res_granted_q <= 1'b0;
      res_client_q  <= '0;
      res_deficit_q <= '0;
    end else begin
      if (cmd_i.load && (in_op_i == OP_PICK)) begin
        ptr_q <= ptr_norm;
        cnt_q <= '0;
      end
      // one client per cycle; a client without work loses its credit
      if (cmd_i.scan && !status_o.cur_ready) begin
        deficit_q[ptr_q] <= '0;
        ptr_q            <= ptr_wrap;
        cnt_q            <= cnt_q + PTR_W'(1);
        res_granted_q    <= 1'b0;
        res_client_q     <= '0;
        res_deficit_q    <= '0;
      end
      if (cmd_i.refill) begin
        deficit_q[ptr_q] <= refill_def;
        last_q           <= ptr_q;
        pending_q        <= 1'b1;
        res_granted_q    <= 1'b1;
        res_client_q     <= ptr_q;
        res_deficit_q    <= refill_def;
      end
      if (cmd_i.exec) begin
        res_granted_q <= 1'b0;
        case (op_q)
          OP_CHARGE: begin
            res_client_q <= last_q;
            if (pending_q) begin
              deficit_q[last_q] <= charge_def;
              pending_q         <= 1'b0;
              res_deficit_q     <= charge_def;
              if (charge_def[DEF_W-1] || (charge_def == '0)) begin
                ptr_q <= ptr_wrap;
              end
            end else begin
              res_deficit_q <= rd_def;
            end
          end
          OP_WEIGHT: begin
            weight_q[client_q]  <= weight_in_q;
            deficit_q[client_q] <= '0;
            res_client_q        <= client_q;
            res_deficit_q       <= '0;
          end
          OP_REMOVE: begin
            deficit_q[client_q] <= '0;
            ptr_q               <= '0;
            if (last_q == client_q) begin
              pending_q <= 1'b0;
            end
            res_client_q  <= client_q;
            res_deficit_q <= '0;
          end
          default: begin
            res_client_q <= client_q;
          end
        endcase
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_granted_o <= res_granted_q;
      out_client_o  <= res_client_q;
      out_pointer_o <= ptr_q;
      out_deficit_o <= res_deficit_q;
    end
  end

`ifndef SYNTHESIS
  // the scan never looks outside the round
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan |-> ({1'b0, ptr_q} < count_q) && ({1'b0, cnt_q} < count_q))
    else $error("scan outside the round");

  // a grant records its client and arms the charge
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.refill |=> pending_q && (last_q == $past(ptr_q)))
    else $error("grant not recorded");

  // a grant reports itself and the client at the pointer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.refill |=> res_granted_q && (res_client_q == $past(ptr_q)))
    else $error("grant not reported");

  // commands are mutually exclusive
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_i.load, cmd_i.scan, cmd_i.refill, cmd_i.exec, cmd_i.out_load}))
    else $error("overlapping commands");
`endif

endmodule

// ===== rtl/deficit_round_robin_scheduler.sv =====
// Deficit round robin scheduler, one item in flight at a time.
// A pick latches the item and scans the round one client per cycle; a client with
// work is refilled and granted, and a pick without a grant scans every client of
// the round. Charge, set weight and remove run a single execute step. The result
// then waits for the output register; a result not taken holds the block.
// A new item is taken once the result moves out; the single-client scan step bounds a pick.
// Reset (rst_ni low, asynchronous): deficits 0, weights 1, pointer 0,
// no pending charge, quantum 1, client count 1, output empty.
module deficit_round_robin_scheduler (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // ready_mask[7:0], client[10:8], job_cost[26:11],
                                      // weight[34:27], zero[39:35]
  input  logic [1:0]  s_axis_tuser,   // opcode[1:0]
  // results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // grant_client[2:0], round_pointer[5:3],
                                      // deficit_after[30:6], zero[31]
  output logic [0:0]  m_axis_tuser,   // granted[0]
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import drr_pkg::*;

  drr_cmd_t         cmd;
  drr_status_t      status;
  logic             out_granted;
  logic [PTR_W-1:0] out_client;
  logic [PTR_W-1:0] out_pointer;
  logic [DEF_W-1:0] out_deficit;

  assign cfg_ready_o = 1'b1;

  drr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_op_i     (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  drr_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_op_i       (s_axis_tuser),
    .in_mask_i     (s_axis_tdata[7:0]),
    .in_client_i   (s_axis_tdata[10:8]),
    .in_cost_i     (s_axis_tdata[26:11]),
    .in_weight_i   (s_axis_tdata[34:27]),
    .out_granted_o (out_granted),
    .out_client_o  (out_client),
    .out_pointer_o (out_pointer),
    .out_deficit_o (out_deficit)
  );

  // Pack the result
  assign m_axis_tdata = {1'b0, out_deficit, out_pointer, out_client};
  assign m_axis_tuser = out_granted;

endmodule

// ===== tb/deficit_round_robin_scheduler_tb.sv =====
module deficit_round_robin_scheduler_tb;
  import drr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int    CYCLE_LIMIT = 200000;
  localparam int    SETTLE_CYCLES = 16;
  localparam longint CREDIT_MAX = 64'sd16777215;
  localparam longint CREDIT_MIN = -64'sd16777216;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  mask;
    logic [2:0]  client;
    logic [15:0] cost;
    logic [7:0]  weight;
  } sched_item_t;

  typedef struct packed {
    logic        granted;
    logic [2:0]  client;
    logic [2:0]  ptr;
    logic [24:0] credit;
  } sched_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;  // ready_mask, client, job_cost, weight, zero pad
  logic [1:0]  s_axis_tuser = '0;  // opcode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;       // grant_client, round_pointer, deficit_after, zero pad
  logic [0:0]  m_axis_tuser;       // granted
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = 1'b0;
  logic [15:0] cfg_data_i = '0;

  // Scheduler state mirror
  int           credit_q [MAX_CLIENTS];
  logic [7:0]   weight_q [MAX_CLIENTS];
  int unsigned  rr_ptr;
  int unsigned  last_grant;
  bit           charge_open;
  logic [15:0]  quantum_cfg;
  logic [3:0]   count_cfg;

  sched_result_t predicted_decisions[$];
  int           decision_errors = 0;
  int           cycle_cnt = 0;
  int           send_idle_pct = 38;
  int           recv_idle_pct = 59;
  int           stall_request = 0;
  int           stall_left = 0;

  deficit_round_robin_scheduler u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("deficit_round_robin_scheduler regression: fail");
      $finish;
    end
  end

  function automatic int clamp_credit(longint v);
    if (v > CREDIT_MAX) return int'(CREDIT_MAX);
    if (v < CREDIT_MIN) return int'(CREDIT_MIN);
    return int'(v);
  endfunction

  // Advance the mirror by one item and return the decision it produces
  function automatic sched_result_t schedule_item(sched_item_t it);
    sched_result_t r;
    int unsigned   n;
    int unsigned   cur;
    bit            found;
    n = (count_cfg == 0) ? 1 : (count_cfg > MAX_CLIENTS) ? MAX_CLIENTS : count_cfg;
    r = '0;
    case (it.op)
      OP_PICK: begin
        if (rr_ptr >= n) rr_ptr = 0;
        found = 1'b0;
        for (int k = 0; k < n && !found; k++) begin
          cur = rr_ptr;
          if (!it.mask[cur]) begin
            // idle client loses its credit and is skipped
            credit_q[cur] = 0;
            rr_ptr = (rr_ptr + 1) % n;
          end else begin
            if (credit_q[cur] <= 0)
              credit_q[cur] = clamp_credit(longint'(credit_q[cur]) +
                                           longint'(weight_q[cur]) * longint'(quantum_cfg));
            last_grant  = cur;
            charge_open = 1'b1;
            found       = 1'b1;
            r.granted   = 1'b1;
            r.client    = cur[2:0];
            r.credit    = 25'(credit_q[cur]);
          end
        end
      end
      OP_CHARGE: begin
        if (charge_open) begin
          credit_q[last_grant] = clamp_credit(longint'(credit_q[last_grant]) -
                                              longint'(it.cost));
          charge_open = 1'b0;
          if (credit_q[last_grant] <= 0) begin
            if (rr_ptr >= n) rr_ptr = 0;
            rr_ptr = (rr_ptr + 1) % n;
          end
        end
        r.client = last_grant[2:0];
        r.credit = 25'(credit_q[last_grant]);
      end
      OP_WEIGHT: begin
        weight_q[it.client] = it.weight;
        credit_q[it.client] = 0;
        r.client = it.client;
      end
      default: begin
        credit_q[it.client] = 0;
        rr_ptr = 0;
        if (charge_open && last_grant == it.client) charge_open = 1'b0;
        r.client = it.client;
      end
    endcase
    r.ptr = rr_ptr[2:0];
    return r;
  endfunction

  // Receiver: random backpressure plus requested long stalls
  always @(posedge clk_i) begin
    if (stall_request > 0) begin
      stall_left = stall_request;
      stall_request = 0;
    end
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic void check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
      decision_errors++;
    end
  endfunction

  // Compare each result transfer with the oldest prediction
  always @(posedge clk_i) begin
    sched_result_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (predicted_decisions.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h/%h", $time,
                 m_axis_tuser, m_axis_tdata);
        decision_errors++;
      end else begin
        e = predicted_decisions.pop_front();
        check_field("granted", e.granted, m_axis_tuser[0]);
        check_field("grant_client", e.client, m_axis_tdata[2:0]);
        check_field("round_pointer", e.ptr, m_axis_tdata[5:3]);
        check_field("deficit_after", int'($signed(e.credit)),
                    int'($signed(m_axis_tdata[30:6])));
      end
    end
  end

  // One input transfer; tvalid stays high into the next item when there is no gap
  task automatic offer_item(input sched_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, it.weight, it.cost, it.client, it.mask};
    s_axis_tuser  <= it.op;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted_decisions.push_back(schedule_item(it));
  endtask

  task automatic pick(input logic [7:0] mask);
    offer_item('{op: OP_PICK, mask: mask, client: 3'($urandom_range(7)),
                 cost: 16'($urandom_range(65535)), weight: 8'($urandom_range(255))});
  endtask

  task automatic charge(input logic [15:0] cost);
    offer_item('{op: OP_CHARGE, mask: 8'($urandom_range(255)),
                 client: 3'($urandom_range(7)), cost: cost,
                 weight: 8'($urandom_range(255))});
  endtask

  task automatic set_weight(input logic [2:0] client, input logic [7:0] weight);
    offer_item('{op: OP_WEIGHT, mask: 8'($urandom_range(255)), client: client,
                 cost: 16'($urandom_range(65535)), weight: weight});
  endtask

  task automatic remove(input logic [2:0] client);
    offer_item('{op: OP_REMOVE, mask: 8'($urandom_range(255)), client: client,
                 cost: 16'($urandom_range(65535)), weight: 8'($urandom_range(255))});
  endtask

  // Stop offering, wait for every result, then let the block go quiet
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (predicted_decisions.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write both registers back to back; only called while idle
  task automatic set_config(input logic [15:0] quantum, input logic [15:0] count);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= REG_QUANTUM;
    cfg_data_i  <= quantum;
    do @(posedge clk_i); while (!cfg_ready_o);
    quantum_cfg = quantum;
    cfg_index_i <= REG_COUNT;
    cfg_data_i  <= count;
    do @(posedge clk_i); while (!cfg_ready_o);
    count_cfg = count[3:0];
    cfg_valid_i <= 1'b0;
  endtask

  // Reset config: one client, quantum of one; stray charge first
  task automatic test_reset_defaults();
    charge(16'd5);
    pick(8'hFE);
    pick(8'h01);
    charge(16'd1);
  endtask

  // Extreme weights and quantum, empty mask, pick over pending, remove of pending
  task automatic test_directed_ops();
    settle();
    set_config(16'hFFFF, 16'd8);
    set_weight(3'd7, 8'hFF);
    set_weight(3'd0, 8'h00);
    pick(8'h00);
    pick(8'h80);
    charge(16'hFFFF);
    pick(8'hFF);
    remove(3'd7);
    charge(16'd9);
    pick(8'h01);
    charge(16'd0);
    pick(8'h02);
    pick(8'h04);
    charge(16'd1);
  endtask

  // Pointer past a shrunken round, mask bits past the round, count 0 and 15
  task automatic test_round_limits();
    settle();
    set_config(16'd1, 16'd2);
    pick(8'hFC);
    pick(8'h03);
    charge(16'd0);
    settle();
    set_config(16'd1, 16'd0);
    pick(8'h02);
    settle();
    set_config(16'd2, 16'd15);
    pick(8'h80);
    charge(16'd3);
  endtask

  // Mostly pick/charge pairs, with weight updates, removes and stray charges
  task automatic random_traffic(input int items);
    int sent;
    int roll;
    sent = 0;
    while (sent < items) begin
      roll = $urandom_range(99);
      if (roll < 65) begin
        pick(($urandom_range(9) == 0) ? 8'h00 : 8'($urandom_range(255)));
        sent++;
        if ($urandom_range(99) < 85) begin
          case ($urandom_range(3))
            0:       charge(16'($urandom_range(15)));
            1:       charge(16'($urandom_range(255)));
            2:       charge(16'($urandom_range(65535)));
            default: charge(16'hFFFF);
          endcase
          sent++;
        end
      end else if (roll < 75) begin
        charge(16'($urandom_range(65535)));
        sent++;
      end else if (roll < 88) begin
        set_weight(3'($urandom_range(7)), ($urandom_range(3) == 0) ?
                   8'($urandom_range(3)) : 8'($urandom_range(255)));
        sent++;
      end else begin
        remove(3'($urandom_range(7)));
        sent++;
      end
    end
  endtask

  // Long receiver stall while the sender keeps offering
  task automatic test_backpressure();
    int saved_idle;
    settle();
    set_config(16'd16, 16'd8);
    saved_idle = send_idle_pct;
    send_idle_pct = 0;
    stall_request = 300;
    random_traffic(20);
    send_idle_pct = saved_idle;
  endtask

  task automatic test_random_phase(input int s_idle, input int r_idle,
                                   input logic [15:0] q_a, input logic [15:0] n_a,
                                   input logic [15:0] q_b, input logic [15:0] n_b);
    settle();
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    set_config(q_a, n_a);
    random_traffic(88);
    settle();
    set_config(q_b, n_b);
    random_traffic(88);
  endtask

  initial begin
    for (int i = 0; i < MAX_CLIENTS; i++) begin
      credit_q[i] = 0;
      weight_q[i] = 8'd1;
    end
    rr_ptr      = 0;
    last_grant  = 0;
    charge_open = 1'b0;
    quantum_cfg = 16'd1;
    count_cfg   = 4'd1;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_directed_ops();
    test_round_limits();
    test_backpressure();
    test_random_phase(38, 59, 16'd300, 16'd8, 16'd1, 16'd5);
    test_random_phase(59, 38, 16'hFFFF, 16'd15, 16'd0, 16'd3);
    test_random_phase(0, 0, 16'd4096, 16'd8,
                      16'($urandom_range(65535)), 16'($urandom_range(15)));
    settle();

    if (decision_errors == 0) begin
      $display("deficit_round_robin_scheduler regression: pass");
    end else begin
      $display("deficit_round_robin_scheduler regression: fail");
    end
    $finish;
  end

endmodule
